// ----- hw/rtl/sls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types and constants of the spring lattice step core: controller
// commands, datapath status, configuration and fixed-point constants.
// ----------------------------------------------------------------------------
package sls_pkg;

   localparam logic [1:0] ACT_LOAD      = 2'd0;
   localparam logic [1:0] ACT_EDGE      = 2'd1;
   localparam logic [1:0] ACT_INTEGRATE = 2'd2;

   localparam logic [1:0] CSR_TENSION = 2'd0;
   localparam logic [1:0] CSR_STEP    = 2'd1;
   localparam logic [1:0] CSR_RETAIN  = 2'd2;

   // 1e-4 in q8.24
   localparam logic [32:0] NEAR_ZERO   = 33'd1678;
   localparam logic [39:0] FORCE_LIMIT = 40'hFF_FFFF_FFFF;

   localparam int ROOT_STEPS = 33;
   localparam int DIV_STEPS  = 24;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RD_A,
      OP_RD_B,
      OP_DELTA,
      OP_SQ,
      OP_SQ_ACC,
      OP_ROOT,
      OP_DIFF,
      OP_MUL_P,
      OP_Q,
      OP_MUL_TL,
      OP_TL,
      OP_MUL_TH,
      OP_F,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL_CL,
      OP_CL,
      OP_MUL_CH,
      OP_C,
      OP_FRC_RD_A,
      OP_FRC_WR_A,
      OP_FRC_WR_B,
      OP_INT_RD,
      OP_MUL_V,
      OP_VEL_T,
      OP_MUL_F,
      OP_NEW_VEL,
      OP_MUL_P_DT,
      OP_NEW_POS,
      OP_INT_WR
   } sls_op_type;

   typedef struct packed {
      logic       capture;
      sls_op_type op;
      logic [1:0] axis;
   } sls_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       first_ok;
      logic       second_ok;
      logic       near_zero;
   } sls_status_type;

   typedef struct packed {
      logic [32:0] tension;
      logic [23:0] time_step;
      logic [24:0] retain_factor;
   } sls_cfg_type;

endpackage

// ----- hw/rtl/sls_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_if
// Valid/ready channels of the spring lattice step core: request items in,
// integrated vertex positions out.
// ----------------------------------------------------------------------------
interface sls_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [10:0]        first_vertex;
   logic [10:0]        second_vertex;
   logic signed [31:0] load_x;
   logic signed [31:0] load_y;
   logic signed [31:0] load_z;
   logic [30:0]        rest_length;
   logic signed [31:0] edge_weight;

   modport source (
      output valid, action, first_vertex, second_vertex, load_x, load_y, load_z,
             rest_length, edge_weight,
      input  ready
   );
   modport sink (
      input  valid, action, first_vertex, second_vertex, load_x, load_y, load_z,
             rest_length, edge_weight,
      output ready
   );
endinterface

interface sls_rsp_if;
   logic               valid;
   logic               ready;
   logic [10:0]        vertex_index;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_z;

   modport source (
      output valid, vertex_index, new_x, new_y, new_z,
      input  ready
   );
   modport sink (
      input  valid, vertex_index, new_x, new_y, new_z,
      output ready
   );
endinterface

// ----- hw/rtl/sls_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_ctrl
// Sequencer of the spring lattice step core. Steps the datapath through
// load, edge and integrate work and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module sls_ctrl
   import sls_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  sls_status_type status,
   output sls_cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE, S_DECODE, S_LOAD,
      S_RDA, S_RDB, S_DELTA, S_SQ, S_SQ_ACC, S_ROOT, S_DIFF,
      S_MUL_P, S_Q, S_MUL_TL, S_TL, S_MUL_TH, S_F,
      S_DIV_INIT, S_DIV_STEP, S_MUL_CL, S_CL, S_MUL_CH, S_C,
      S_FRC_RD_A, S_FRC_WR_A, S_FRC_WR_B,
      S_INT_RD, S_MUL_V, S_VEL_T, S_MUL_F, S_NEW_VEL, S_MUL_P_DT, S_NEW_POS, S_INT_WR
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      cnt_in      = cnt_ff;
      cmd.capture = 1'b0;
      cmd.op      = OP_NONE;
      cmd.axis    = axis_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (status.action == ACT_LOAD && status.first_ok) begin
               state_in = S_LOAD;
            end else if (status.action == ACT_EDGE && status.first_ok && status.second_ok) begin
               state_in = S_RDA;
            end else if (status.action == ACT_INTEGRATE && status.first_ok) begin
               state_in = S_INT_RD;
            end
            axis_in = 2'd0;
            cnt_in  = 6'd0;
         end
         S_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = S_IDLE;
         end
         S_RDA: begin
            cmd.op   = OP_RD_A;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.op   = OP_RD_B;
            state_in = S_DELTA;
         end
         S_DELTA: begin
            cmd.op   = OP_DELTA;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op   = OP_SQ;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.op = OP_SQ_ACC;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = S_ROOT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_SQ;
            end
         end
         S_ROOT: begin
            cmd.op = OP_ROOT;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROOT_STEPS - 1)) begin
               cnt_in   = 6'd0;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            if (status.near_zero) begin
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_DIFF;
               state_in = S_MUL_P;
            end
         end
         S_MUL_P: begin
            cmd.op   = OP_MUL_P;
            state_in = S_Q;
         end
         S_Q: begin
            cmd.op   = OP_Q;
            state_in = S_MUL_TL;
         end
         S_MUL_TL: begin
            cmd.op   = OP_MUL_TL;
            state_in = S_TL;
         end
         S_TL: begin
            cmd.op   = OP_TL;
            state_in = S_MUL_TH;
         end
         S_MUL_TH: begin
            cmd.op   = OP_MUL_TH;
            state_in = S_F;
         end
         S_F: begin
            cmd.op   = OP_F;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               cnt_in   = 6'd0;
               state_in = S_MUL_CL;
            end
         end
         S_MUL_CL: begin
            cmd.op   = OP_MUL_CL;
            state_in = S_CL;
         end
         S_CL: begin
            cmd.op   = OP_CL;
            state_in = S_MUL_CH;
         end
         S_MUL_CH: begin
            cmd.op   = OP_MUL_CH;
            state_in = S_C;
         end
         S_C: begin
            cmd.op = OP_C;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = S_FRC_RD_A;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_DIV_INIT;
            end
         end
         S_FRC_RD_A: begin
            cmd.op   = OP_FRC_RD_A;
            state_in = S_FRC_WR_A;
         end
         S_FRC_WR_A: begin
            cmd.op   = OP_FRC_WR_A;
            state_in = S_FRC_WR_B;
         end
         S_FRC_WR_B: begin
            cmd.op   = OP_FRC_WR_B;
            state_in = S_IDLE;
         end
         S_INT_RD: begin
            cmd.op   = OP_INT_RD;
            state_in = S_MUL_V;
         end
         S_MUL_V: begin
            cmd.op   = OP_MUL_V;
            state_in = S_VEL_T;
         end
         S_VEL_T: begin
            cmd.op   = OP_VEL_T;
            state_in = S_MUL_F;
         end
         S_MUL_F: begin
            cmd.op   = OP_MUL_F;
            state_in = S_NEW_VEL;
         end
         S_NEW_VEL: begin
            cmd.op   = OP_NEW_VEL;
            state_in = S_MUL_P_DT;
         end
         S_MUL_P_DT: begin
            cmd.op   = OP_MUL_P_DT;
            state_in = S_NEW_POS;
         end
         S_NEW_POS: begin
            cmd.op = OP_NEW_POS;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = S_INT_WR;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_MUL_V;
            end
         end
         S_INT_WR: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_INT_WR;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 2'd0;
         cnt_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/sls_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_dpath
// Datapath of the spring lattice step core: vertex stores, shared
// multiplier, bit-serial square root and divider, saturating accumulators.
// ----------------------------------------------------------------------------
module sls_dpath
   import sls_pkg::*;
#(
   parameter int VERTEX_COUNT = 1536
) (
   input  logic               clock,
   input  sls_cmd_type        cmd,
   input  sls_cfg_type        cfg,
   input  logic [1:0]         req_action,
   input  logic [10:0]        req_first_vertex,
   input  logic [10:0]        req_second_vertex,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_z,
   input  logic [30:0]        req_rest_length,
   input  logic signed [31:0] req_edge_weight,
   output sls_status_type     status,
   output logic [10:0]        rsp_vertex_index,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y,
   output logic signed [31:0] rsp_new_z
);

   function automatic logic signed [31:0] lane(input logic [95:0] w, input logic [1:0] k);
      case (k)
         2'd0:    return $signed(w[31:0]);
         2'd1:    return $signed(w[63:32]);
         default: return $signed(w[95:64]);
      endcase
   endfunction

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [33:0] signed_mag(input logic neg, input logic [31:0] m);
      return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      if (v > 43'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -43'sh0_8000_0000) return -32'sh8000_0000;
      return 32'(v);
   endfunction

   logic [95:0] pos_mem [VERTEX_COUNT];
   logic [95:0] vel_mem [VERTEX_COUNT];
   logic [95:0] frc_mem [VERTEX_COUNT];
   logic [95:0] pos_rd_ff, vel_rd_ff, frc_rd_ff;

   logic [1:0]         act_ff;
   logic [10:0]        v1_ff, v2_ff;
   logic [95:0]        ld_ff;
   logic [30:0]        rest_ff;
   logic signed [31:0] weight_ff;

   logic [95:0]        pa_ff;
   logic signed [32:0] delta_ff [3];
   logic [65:0]        sum_ff;
   logic [35:0]        rem_ff;
   logic [33:0]        root_ff;
   logic [33:0]        absdiff_ff;
   logic               fneg_ff;
   logic [41:0]        q_ff;
   logic [56:0]        tl_ff;
   logic [39:0]        f_ff;
   logic [32:0]        drem_ff;
   logic [24:0]        quot_ff;
   logic [44:0]        cl_ff;
   logic signed [41:0] c_ff [3];
   logic signed [33:0] t1_ff;
   logic signed [31:0] nv_ff [3];
   logic signed [31:0] np_ff [3];
   logic [10:0]        out_idx_ff;
   logic [95:0]        out_pos_ff;

   logic [33:0] mul_a;
   logic [32:0] mul_b;
   logic [66:0] mul_ff;

   logic [32:0]        edge_len;
   logic [32:0]        mag_k;
   logic signed [34:0] diff;
   logic [35:0]        rem_n, trial;
   logic [74:0]        fsum;
   logic [33:0]        r2;
   logic [64:0]        csum;
   logic [40:0]        cmag;
   logic signed [33:0] t2, t3;
   logic [95:0]        frc_new;

   assign edge_len = root_ff[32:0];
   assign mag_k    = mag33(delta_ff[cmd.axis]);
   assign diff     = $signed({2'b00, edge_len}) - $signed({4'b0000, rest_ff});
   assign rem_n    = {rem_ff[33:0], sum_ff[65:64]};
   assign trial    = {root_ff, 2'b01};
   assign fsum     = {mul_ff[50:0], 24'd0} + {18'd0, tl_ff};
   assign r2       = {drem_ff, 1'b0};
   assign csum     = {mul_ff[44:0], 20'd0} + {20'd0, cl_ff};
   assign cmag     = csum[64:24];
   assign t2       = signed_mag(lane(frc_rd_ff, cmd.axis) < 0, mul_ff[55:24]);
   assign t3       = signed_mag(nv_ff[cmd.axis] < 0, mul_ff[55:24]);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SQ: begin
            mul_a = {1'b0, mag_k};
            mul_b = mag_k;
         end
         OP_MUL_P: begin
            mul_a = absdiff_ff;
            mul_b = {1'b0, mag32(weight_ff)};
         end
         OP_MUL_TL: begin
            mul_a = {10'd0, q_ff[23:0]};
            mul_b = cfg.tension;
         end
         OP_MUL_TH: begin
            mul_a = {16'd0, q_ff[41:24]};
            mul_b = cfg.tension;
         end
         OP_MUL_CL: begin
            mul_a = {14'd0, f_ff[19:0]};
            mul_b = {8'd0, quot_ff};
         end
         OP_MUL_CH: begin
            mul_a = {14'd0, f_ff[39:20]};
            mul_b = {8'd0, quot_ff};
         end
         OP_MUL_V: begin
            mul_a = {2'b00, mag32(lane(vel_rd_ff, cmd.axis))};
            mul_b = {8'd0, cfg.retain_factor};
         end
         OP_MUL_F: begin
            mul_a = {2'b00, mag32(lane(frc_rd_ff, cmd.axis))};
            mul_b = {9'd0, cfg.time_step};
         end
         OP_MUL_P_DT: begin
            mul_a = {2'b00, mag32(nv_ff[cmd.axis])};
            mul_b = {9'd0, cfg.time_step};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      frc_new = '0;
      for (int k = 0; k < 3; k++) begin
         if (cmd.op == OP_FRC_WR_A) begin
            frc_new[32*k +: 32] = sat32(43'(lane(frc_rd_ff, 2'(k))) + 43'(c_ff[k]));
         end else begin
            frc_new[32*k +: 32] = sat32(43'(lane(frc_rd_ff, 2'(k))) - 43'(c_ff[k]));
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         act_ff    <= req_action;
         v1_ff     <= req_first_vertex;
         v2_ff     <= req_second_vertex;
         ld_ff     <= {req_load_z, req_load_y, req_load_x};
         rest_ff   <= req_rest_length;
         weight_ff <= req_edge_weight;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            pos_mem[v1_ff] <= ld_ff;
            vel_mem[v1_ff] <= '0;
            frc_mem[v1_ff] <= '0;
         end
         OP_RD_A: pos_rd_ff <= pos_mem[v1_ff];
         OP_RD_B: begin
            pa_ff     <= pos_rd_ff;
            pos_rd_ff <= pos_mem[v2_ff];
         end
         OP_DELTA: begin
            for (int k = 0; k < 3; k++) begin
               delta_ff[k] <= 33'(lane(pos_rd_ff, 2'(k))) - 33'(lane(pa_ff, 2'(k)));
            end
            sum_ff  <= '0;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         OP_SQ_ACC: sum_ff <= sum_ff + {1'b0, mul_ff[64:0]};
         OP_ROOT: begin
            sum_ff <= {sum_ff[63:0], 2'b00};
            if (rem_n >= trial) begin
               rem_ff  <= rem_n - trial;
               root_ff <= {root_ff[32:0], 1'b1};
            end else begin
               rem_ff  <= rem_n;
               root_ff <= {root_ff[32:0], 1'b0};
            end
         end
         OP_DIFF: begin
            absdiff_ff <= diff[34] ? 34'(-diff) : 34'(diff);
            fneg_ff    <= diff[34] ^ weight_ff[31];
         end
         OP_Q:  q_ff  <= mul_ff[65:24];
         OP_TL: tl_ff <= mul_ff[56:0];
         OP_F: begin
            if (fsum[74:16] > {19'd0, FORCE_LIMIT}) f_ff <= FORCE_LIMIT;
            else f_ff <= fsum[55:16];
         end
         OP_DIV_INIT: begin
            if (mag_k >= edge_len) begin
               drem_ff <= mag_k - edge_len;
               quot_ff <= 25'd1;
            end else begin
               drem_ff <= mag_k;
               quot_ff <= 25'd0;
            end
         end
         OP_DIV_STEP: begin
            if (r2 >= {1'b0, edge_len}) begin
               drem_ff <= 33'(r2 - {1'b0, edge_len});
               quot_ff <= {quot_ff[23:0], 1'b1};
            end else begin
               drem_ff <= r2[32:0];
               quot_ff <= {quot_ff[23:0], 1'b0};
            end
         end
         OP_CL: cl_ff <= mul_ff[44:0];
         OP_C: begin
            if (fneg_ff ^ delta_ff[cmd.axis][32]) c_ff[cmd.axis] <= -$signed({1'b0, cmag});
            else c_ff[cmd.axis] <= $signed({1'b0, cmag});
         end
         OP_FRC_RD_A: frc_rd_ff <= frc_mem[v1_ff];
         OP_FRC_WR_A: begin
            frc_mem[v1_ff] <= frc_new;
            frc_rd_ff      <= frc_mem[v2_ff];
         end
         OP_FRC_WR_B: frc_mem[v2_ff] <= frc_new;
         OP_INT_RD: begin
            pos_rd_ff <= pos_mem[v1_ff];
            vel_rd_ff <= vel_mem[v1_ff];
            frc_rd_ff <= frc_mem[v1_ff];
         end
         OP_VEL_T: t1_ff <= signed_mag(lane(vel_rd_ff, cmd.axis) < 0, mul_ff[55:24]);
         OP_NEW_VEL: nv_ff[cmd.axis] <= sat32(43'(t1_ff) + 43'(t2));
         OP_NEW_POS: np_ff[cmd.axis] <= sat32(43'(lane(pos_rd_ff, cmd.axis)) + 43'(t3));
         OP_INT_WR: begin
            pos_mem[v1_ff] <= {np_ff[2], np_ff[1], np_ff[0]};
            vel_mem[v1_ff] <= {nv_ff[2], nv_ff[1], nv_ff[0]};
            frc_mem[v1_ff] <= '0;
            out_idx_ff     <= v1_ff;
            out_pos_ff     <= {np_ff[2], np_ff[1], np_ff[0]};
         end
         default: begin
         end
      endcase
   end

   assign status.action    = act_ff;
   assign status.first_ok  = 32'(v1_ff) < VERTEX_COUNT;
   assign status.second_ok = 32'(v2_ff) < VERTEX_COUNT;
   assign status.near_zero = edge_len < NEAR_ZERO;

   assign rsp_vertex_index = out_idx_ff;
   assign rsp_new_x        = $signed(out_pos_ff[31:0]);
   assign rsp_new_y        = $signed(out_pos_ff[63:32]);
   assign rsp_new_z        = $signed(out_pos_ff[95:64]);

endmodule

// ----- hw/rtl/spring_lattice_step_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_lattice_step_core
// Fixed-point mass-spring lattice solver over a vertex store.
//
// Requests arrive on req_chan, one transfer per item: load a vertex, apply
// an edge spring, or integrate a vertex. Only integrate produces a transfer
// on rsp_chan with the vertex index and its new position.
// Items run one at a time. An edge is dominated by the 33-step square root,
// three 24-step divisions and one shared multiplier; an edge whose length is
// near zero skips the force update. An integrate does three multiplies per axis.
// The result sits in an output register; a stalled receiver holds only the
// next integrate at its final write, other items keep flowing.
// Reset clears the sequencer and the result valid and restores the
// configuration defaults; vertex stores hold garbage until loaded.
// Configuration: APB-style, 64-bit data, registers at 0x00, 0x08, 0x10.
// ----------------------------------------------------------------------------
module spring_lattice_step_core
   import sls_pkg::*;
#(
   parameter int VERTEX_COUNT = 1536
) (
   input  logic        clock,
   input  logic        reset,
   sls_req_if.sink     req_chan,
   sls_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   sls_cfg_type    cfg_ff;
   sls_cmd_type    cmd;
   sls_status_type status;
   logic           csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tension       <= 33'd65536;
         cfg_ff.time_step     <= 24'd16777;
         cfg_ff.retain_factor <= 25'd16777216;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:3])
            CSR_TENSION: cfg_ff.tension       <= csr_pwdata[32:0];
            CSR_STEP:    cfg_ff.time_step     <= csr_pwdata[23:0];
            CSR_RETAIN:  cfg_ff.retain_factor <= csr_pwdata[24:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:3])
         CSR_TENSION: csr_prdata = {31'd0, cfg_ff.tension};
         CSR_STEP:    csr_prdata = {40'd0, cfg_ff.time_step};
         CSR_RETAIN:  csr_prdata = {39'd0, cfg_ff.retain_factor};
         default:     csr_prdata = '0;
      endcase
   end

   sls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sls_dpath #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_dpath (
      .clock             (clock),
      .cmd               (cmd),
      .cfg               (cfg_ff),
      .req_action        (req_chan.action),
      .req_first_vertex  (req_chan.first_vertex),
      .req_second_vertex (req_chan.second_vertex),
      .req_load_x        (req_chan.load_x),
      .req_load_y        (req_chan.load_y),
      .req_load_z        (req_chan.load_z),
      .req_rest_length   (req_chan.rest_length),
      .req_edge_weight   (req_chan.edge_weight),
      .status            (status),
      .rsp_vertex_index  (rsp_chan.vertex_index),
      .rsp_new_x         (rsp_chan.new_x),
      .rsp_new_y         (rsp_chan.new_y),
      .rsp_new_z         (rsp_chan.new_z)
   );

endmodule
